/* hw/rtl/pkwrl_pkg.sv */
// shared constants and types for the per-key window rate limiter
// no dependencies

package pkwrl_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int KEY_BITS_DEF    = 64;

  localparam int KEY_W   = 64;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 17;
  localparam int RL_W    = 16;
  localparam int WS_W    = 16;
  localparam int TKL_W   = 7;
  localparam int USED_W  = 7;
  localparam int CFG_IDX_W = 2;
  localparam int WMS_W   = 26;

  localparam logic [9:0]        MS_PER_SEC    = 10'd1000;
  localparam logic [TIME_W-1:0] CLEAN_PERIOD  = 32'd1000;
  localparam logic [TKL_W-1:0]  TKL_RESET     = 7'd64;

  localparam logic CMD_CHECK  = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRACKED_LIMIT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POST,
    ST_EVCHK,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MODE_CLEAN,
    MODE_OLDEST,
    MODE_FIND
  } scan_mode_t;

endpackage

/* hw/rtl/pkwrl_mem.sv */
// slot table storage: key, count, window start and last seen per slot
// one write port, one registered read port; uses pkwrl_pkg

module pkwrl_mem #(
  parameter int DEPTH = pkwrl_pkg::TABLE_DEPTH_DEF,
  parameter int KW    = pkwrl_pkg::KEY_BITS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [KW-1:0]                 wkey,
  input  logic [pkwrl_pkg::CNT_W-1:0]   wcnt,
  input  logic [pkwrl_pkg::TIME_W-1:0]  wws,
  input  logic [pkwrl_pkg::TIME_W-1:0]  wls,
  input  logic [AW-1:0]                 raddr,
  output logic [KW-1:0]                 rkey,
  output logic [pkwrl_pkg::CNT_W-1:0]   rcnt,
  output logic [pkwrl_pkg::TIME_W-1:0]  rws,
  output logic [pkwrl_pkg::TIME_W-1:0]  rls
);

  logic [KW-1:0]                key_mem [DEPTH];
  logic [pkwrl_pkg::CNT_W-1:0]  cnt_mem [DEPTH];
  logic [pkwrl_pkg::TIME_W-1:0] ws_mem  [DEPTH];
  logic [pkwrl_pkg::TIME_W-1:0] ls_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      cnt_mem[waddr] <= wcnt;
      ws_mem[waddr]  <= wws;
      ls_mem[waddr]  <= wls;
    end
    rkey <= key_mem[raddr];
    rcnt <= cnt_mem[raddr];
    rws  <= ws_mem[raddr];
    rls  <= ls_mem[raddr];
  end

endmodule

/* hw/rtl/per_key_window_rate_limiter.sv */
// top level: per-key fixed window rate limiter over a bounded slot table
// uses pkwrl_pkg and pkwrl_mem
//
// channel | direction | beat contents
// in_     | input     | command, key_id, key_present, time_ms
// out_    | output    | allowed, window_count, entries_used
// cfg_    | input     | index, data
//
// one item at a time; a scan reads one slot per cycle
// check: up to 1 pass for idle drop, 1 pass per oldest eviction, 1 lookup pass
// results wait in an output register; the next item is taken meanwhile
// synchronous active-low reset clears valid bits, counts and state

module per_key_window_rate_limiter #(
  parameter int TABLE_DEPTH = pkwrl_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = pkwrl_pkg::KEY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_command,
  input  logic [pkwrl_pkg::KEY_W-1:0]       in_key_id,
  input  logic                              in_key_present,
  input  logic [pkwrl_pkg::TIME_W-1:0]      in_time_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_allowed,
  output logic [pkwrl_pkg::CNT_W-1:0]       out_window_count,
  output logic [pkwrl_pkg::USED_W-1:0]      out_entries_used,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pkwrl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pkwrl_pkg::RL_W-1:0]        cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = (CW > pkwrl_pkg::TKL_W) ? CW : pkwrl_pkg::TKL_W;
  localparam int TW = pkwrl_pkg::TIME_W;
  localparam int NW = pkwrl_pkg::CNT_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

  pkwrl_pkg::state_t     state_r, state_nxt;
  pkwrl_pkg::scan_mode_t mode_r, mode_nxt;

  logic [pkwrl_pkg::RL_W-1:0]  rl_r;
  logic [pkwrl_pkg::WS_W-1:0]  ws_r;
  logic [pkwrl_pkg::TKL_W-1:0] tkl_r;
  logic [pkwrl_pkg::WMS_W-1:0] wms_r;
  logic [TW-1:0]               clean_time_r, clean_time_nxt;
  logic [TABLE_DEPTH-1:0]      valid_r, valid_nxt;
  logic [CW-1:0]               total_r, total_nxt;

  logic                        cmd_r;
  logic [KEY_BITS-1:0]         key_r;
  logic [TW-1:0]               now_r;

  logic [AW:0]                 scan_cnt_r, scan_cnt_nxt;
  logic                        pend_r, pend_nxt;
  logic [AW-1:0]               pidx_r, pidx_nxt;
  logic                        found_r, found_nxt;
  logic [AW-1:0]               fslot_r, fslot_nxt;
  logic [NW-1:0]               fcnt_r, fcnt_nxt;
  logic [TW-1:0]               fws_r, fws_nxt;
  logic                        have_best_r, have_best_nxt;
  logic [AW-1:0]               best_r, best_nxt;
  logic [TW-1:0]               best_age_r, best_age_nxt;
  logic                        have_free_r, have_free_nxt;
  logic [AW-1:0]               free_r, free_nxt;

  logic                        res_allowed_r, res_allowed_nxt;
  logic [NW-1:0]               res_count_r, res_count_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_allowed_r, out_allowed_nxt;
  logic [NW-1:0]               out_count_r, out_count_nxt;
  logic [pkwrl_pkg::USED_W-1:0] out_used_r, out_used_nxt;

  logic [KEY_BITS-1:0]         rd_key;
  logic [NW-1:0]               rd_cnt;
  logic [TW-1:0]               rd_ws, rd_ls;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [NW-1:0]               mem_wcnt;
  logic [TW-1:0]               mem_wws;

  logic [LW-1:0]               lim;
  logic [LW-1:0]               total_w;
  logic [TW-1:0]               wms_w;
  logic [TW-1:0]               age;
  logic                        in_fire, cfg_fire, cfg_hit, issue;
  logic [AW-1:0]               ins_slot;
  logic [NW-1:0]               inc_cnt;

  pkwrl_mem #(
    .DEPTH (TABLE_DEPTH),
    .KW    (KEY_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wkey  (key_r),
    .wcnt  (mem_wcnt),
    .wws   (mem_wws),
    .wls   (now_r),
    .raddr (scan_cnt_r[AW-1:0]),
    .rkey  (rd_key),
    .rcnt  (rd_cnt),
    .rws   (rd_ws),
    .rls   (rd_ls)
  );

  assign in_ready  = (state_r == pkwrl_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_fire && (cfg_index == pkwrl_pkg::REG_REQUEST_LIMIT ||
                                  cfg_index == pkwrl_pkg::REG_WINDOW_SECS ||
                                  cfg_index == pkwrl_pkg::REG_TRACKED_LIMIT);

  assign out_valid        = out_valid_r;
  assign out_allowed      = out_allowed_r;
  assign out_window_count = out_count_r;
  assign out_entries_used = out_used_r;

  assign total_w = LW'(total_r);
  assign wms_w   = TW'(wms_r);
  assign age     = now_r - rd_ls;
  assign issue   = (scan_cnt_r < (AW + 1)'(TABLE_DEPTH));
  assign inc_cnt = (fcnt_r <= NW'(rl_r)) ? fcnt_r + NW'(1) : fcnt_r;

  always_comb begin
    if (tkl_r == '0) begin
      lim = LW'(1);
    end else if (LW'(tkl_r) > LW'(TABLE_DEPTH)) begin
      lim = LW'(TABLE_DEPTH);
    end else begin
      lim = LW'(tkl_r);
    end
  end

  always_comb begin
    if (have_free_r && (!have_best_r || free_r < best_r || total_w < lim)) begin
      ins_slot = free_r;
    end else begin
      ins_slot = best_r;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    clean_time_nxt  = clean_time_r;
    valid_nxt       = valid_r;
    total_nxt       = total_r;
    scan_cnt_nxt    = scan_cnt_r;
    pend_nxt        = 1'b0;
    pidx_nxt        = pidx_r;
    found_nxt       = found_r;
    fslot_nxt       = fslot_r;
    fcnt_nxt        = fcnt_r;
    fws_nxt         = fws_r;
    have_best_nxt   = have_best_r;
    best_nxt        = best_r;
    best_age_nxt    = best_age_r;
    have_free_nxt   = have_free_r;
    free_nxt        = free_r;
    res_allowed_nxt = res_allowed_r;
    res_count_nxt   = res_count_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_allowed_nxt = out_allowed_r;
    out_count_nxt   = out_count_r;
    out_used_nxt    = out_used_r;
    mem_we          = 1'b0;
    mem_waddr       = fslot_r;
    mem_wcnt        = NW'(1);
    mem_wws         = now_r;

    case (state_r)
      pkwrl_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_allowed_nxt = 1'b0;
          res_count_nxt   = '0;
          scan_cnt_nxt    = '0;
          found_nxt       = 1'b0;
          have_best_nxt   = 1'b0;
          have_free_nxt   = 1'b0;
          mode_nxt        = pkwrl_pkg::MODE_FIND;
          if (!in_key_present) begin
            state_nxt = pkwrl_pkg::ST_DONE;
          end else if (in_command == pkwrl_pkg::CMD_REMOVE) begin
            state_nxt = pkwrl_pkg::ST_SCAN;
          end else if (rl_r == '0 || ws_r == '0) begin
            state_nxt = pkwrl_pkg::ST_DONE;
          end else begin
            state_nxt = pkwrl_pkg::ST_SCAN;
            if ((in_time_ms - clean_time_r) >= pkwrl_pkg::CLEAN_PERIOD ||
                total_w > lim) begin
              mode_nxt       = pkwrl_pkg::MODE_CLEAN;
              clean_time_nxt = in_time_ms;
            end
          end
        end
      end
      pkwrl_pkg::ST_SCAN: begin
        if (issue) begin
          scan_cnt_nxt = scan_cnt_r + (AW + 1)'(1);
        end
        pend_nxt = issue;
        pidx_nxt = scan_cnt_r[AW-1:0];
        if (pend_r) begin
          if (mode_r == pkwrl_pkg::MODE_CLEAN) begin
            if (valid_r[pidx_r] && age > wms_w) begin
              valid_nxt[pidx_r] = 1'b0;
              total_nxt         = total_r - CW'(1);
            end
          end else if (valid_r[pidx_r]) begin
            if (!have_best_r || age > best_age_r) begin
              have_best_nxt = 1'b1;
              best_nxt      = pidx_r;
              best_age_nxt  = age;
            end
            if (mode_r == pkwrl_pkg::MODE_FIND && !found_r && rd_key == key_r) begin
              found_nxt = 1'b1;
              fslot_nxt = pidx_r;
              fcnt_nxt  = rd_cnt;
              fws_nxt   = rd_ws;
            end
          end else if (!have_free_r) begin
            have_free_nxt = 1'b1;
            free_nxt      = pidx_r;
          end
          if (pidx_r == LAST_SLOT) begin
            state_nxt = pkwrl_pkg::ST_POST;
          end
        end
      end
      pkwrl_pkg::ST_POST: begin
        state_nxt = pkwrl_pkg::ST_DONE;
        case (mode_r)
          pkwrl_pkg::MODE_CLEAN: begin
            state_nxt = pkwrl_pkg::ST_EVCHK;
          end
          pkwrl_pkg::MODE_OLDEST: begin
            state_nxt = pkwrl_pkg::ST_EVCHK;
            if (have_best_r) begin
              valid_nxt[best_r] = 1'b0;
              total_nxt         = total_r - CW'(1);
            end
          end
          default: begin
            if (cmd_r == pkwrl_pkg::CMD_REMOVE) begin
              if (found_r) begin
                valid_nxt[fslot_r] = 1'b0;
                total_nxt          = total_r - CW'(1);
              end
            end else if (found_r) begin
              mem_we          = 1'b1;
              res_allowed_nxt = 1'b1;
              res_count_nxt   = NW'(1);
              if ((now_r - fws_r) <= wms_w) begin
                mem_wcnt        = inc_cnt;
                mem_wws         = fws_r;
                res_count_nxt   = inc_cnt;
                res_allowed_nxt = (inc_cnt <= NW'(rl_r));
              end
            end else begin
              mem_we          = 1'b1;
              mem_waddr       = ins_slot;
              res_allowed_nxt = 1'b1;
              res_count_nxt   = NW'(1);
              if (total_w >= lim) begin
                valid_nxt[best_r] = 1'b0;
              end else begin
                total_nxt = total_r + CW'(1);
              end
              valid_nxt[ins_slot] = 1'b1;
            end
          end
        endcase
      end
      pkwrl_pkg::ST_EVCHK: begin
        state_nxt     = pkwrl_pkg::ST_SCAN;
        scan_cnt_nxt  = '0;
        found_nxt     = 1'b0;
        have_best_nxt = 1'b0;
        have_free_nxt = 1'b0;
        mode_nxt      = (total_w > lim) ? pkwrl_pkg::MODE_OLDEST : pkwrl_pkg::MODE_FIND;
      end
      pkwrl_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_allowed_nxt = res_allowed_r;
          out_count_nxt   = res_count_r;
          out_used_nxt    = pkwrl_pkg::USED_W'(total_r);
          state_nxt       = pkwrl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pkwrl_pkg::ST_IDLE;
      end
    endcase

    if (cfg_hit) begin
      valid_nxt      = '0;
      total_nxt      = '0;
      clean_time_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pkwrl_pkg::ST_IDLE;
      mode_r       <= pkwrl_pkg::MODE_FIND;
      rl_r         <= '0;
      ws_r         <= '0;
      tkl_r        <= pkwrl_pkg::TKL_RESET;
      clean_time_r <= '0;
      valid_r      <= '0;
      total_r      <= '0;
      scan_cnt_r   <= '0;
      pend_r       <= 1'b0;
      found_r      <= 1'b0;
      have_best_r  <= 1'b0;
      have_free_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      clean_time_r <= clean_time_nxt;
      valid_r      <= valid_nxt;
      total_r      <= total_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      pend_r       <= pend_nxt;
      found_r      <= found_nxt;
      have_best_r  <= have_best_nxt;
      have_free_r  <= have_free_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_fire) begin
        case (cfg_index)
          pkwrl_pkg::REG_REQUEST_LIMIT: rl_r  <= cfg_data;
          pkwrl_pkg::REG_WINDOW_SECS:   ws_r  <= cfg_data;
          pkwrl_pkg::REG_TRACKED_LIMIT: tkl_r <= cfg_data[pkwrl_pkg::TKL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    wms_r         <= pkwrl_pkg::WMS_W'(ws_r) * pkwrl_pkg::WMS_W'(pkwrl_pkg::MS_PER_SEC);
    pidx_r        <= pidx_nxt;
    fslot_r       <= fslot_nxt;
    fcnt_r        <= fcnt_nxt;
    fws_r         <= fws_nxt;
    best_r        <= best_nxt;
    best_age_r    <= best_age_nxt;
    free_r        <= free_nxt;
    res_allowed_r <= res_allowed_nxt;
    res_count_r   <= res_count_nxt;
    out_allowed_r <= out_allowed_nxt;
    out_count_r   <= out_count_nxt;
    out_used_r    <= out_used_nxt;
    if (in_fire) begin
      cmd_r <= in_command;
      key_r <= in_key_id[KEY_BITS-1:0];
      now_r <= in_time_ms;
    end
  end

  a_total_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(total_r))
    else $error("entry count differs from valid bits");

  a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) <= TABLE_DEPTH)
    else $error("entry count above table depth");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_done_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == pkwrl_pkg::ST_DONE)
    else $error("result beat raised outside completion");

endmodule

/* tb/sv/rate_limit_checker.sv */
`timescale 1ns / 1ps
// checker for the per-key window rate limiter: watches cfg, in and out beats,
// keeps its own copy of the key table and compares each out beat; uses pkwrl_pkg

module rate_limit_checker
  import pkwrl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_command,
  input  logic [KEY_W-1:0]     in_key_id,
  input  logic                 in_key_present,
  input  logic [TIME_W-1:0]    in_time_ms,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_allowed,
  input  logic [CNT_W-1:0]     out_window_count,
  input  logic [USED_W-1:0]    out_entries_used,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RL_W-1:0]      cfg_data,
  output int                   pending,
  output int                   failures
);
  localparam int DEPTH = TABLE_DEPTH_DEF;

  typedef struct packed {
    logic             allowed;
    logic [CNT_W-1:0] count;
    logic [USED_W-1:0] used;
  } verdict_t;

  verdict_t verdict_q[$];
  int errs = 0;

  logic [RL_W-1:0]   req_limit;
  logic [WS_W-1:0]   win_secs;
  logic [TKL_W-1:0]  key_cap;
  logic              tv[DEPTH];
  logic [KEY_W-1:0]  tkey[DEPTH];
  logic [CNT_W-1:0]  tcnt[DEPTH];
  logic [TIME_W-1:0] tstart[DEPTH];
  logic [TIME_W-1:0] tseen[DEPTH];
  logic [TIME_W-1:0] sweep_time;
  int                live;

  assign pending  = verdict_q.size();
  assign failures = errs;

  task automatic report(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errs++;
  endtask

  task automatic wipe_table();
    for (int i = 0; i < DEPTH; i++) tv[i] = 1'b0;
    live = 0;
    sweep_time = '0;
  endtask

  task automatic drop(int i);
    if (tv[i]) begin
      tv[i] = 1'b0;
      live--;
    end
  endtask

  task automatic evict_stalest(logic [TIME_W-1:0] now);
    int best;
    logic [TIME_W-1:0] best_age, age;
    best = -1;
    best_age = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (tv[i]) begin
        age = now - tseen[i];
        if (best < 0 || age > best_age) begin
          best = i;
          best_age = age;
        end
      end
    end
    if (best >= 0) drop(best);
  endtask

  function automatic int find_slot(logic [KEY_W-1:0] k);
    for (int i = 0; i < DEPTH; i++) if (tv[i] && tkey[i] == k) return i;
    return -1;
  endfunction

  task automatic rate_decision(logic cmd, logic [KEY_W-1:0] k, logic pres,
                               logic [TIME_W-1:0] now, output verdict_t v);
    int s, lim;
    logic [TIME_W-1:0] wms;
    v = '0;
    lim = (key_cap == 0) ? 1 : (key_cap > DEPTH) ? DEPTH : key_cap;
    wms = win_secs * 32'd1000;
    if (cmd == CMD_REMOVE) begin
      if (pres) begin
        s = find_slot(k);
        if (s >= 0) drop(s);
      end
    end else if (pres && req_limit != 0 && win_secs != 0) begin
      if (TIME_W'(now - sweep_time) >= CLEAN_PERIOD || live > lim) begin
        for (int i = 0; i < DEPTH; i++)
          if (tv[i] && TIME_W'(now - tseen[i]) > wms) drop(i);
        while (live > lim) evict_stalest(now);
        sweep_time = now;
      end
      s = find_slot(k);
      if (s < 0) begin
        if (live >= lim) evict_stalest(now);
        for (int i = 0; i < DEPTH; i++) begin
          if (!tv[i]) begin
            tv[i] = 1'b1;
            tkey[i] = k;
            tcnt[i] = 1;
            tstart[i] = now;
            tseen[i] = now;
            live++;
            break;
          end
        end
        v.allowed = 1'b1;
        v.count = 1;
      end else if (TIME_W'(now - tstart[s]) > wms) begin
        tcnt[s] = 1;
        tstart[s] = now;
        tseen[s] = now;
        v.allowed = 1'b1;
        v.count = 1;
      end else begin
        if (tcnt[s] <= req_limit) tcnt[s]++;
        tseen[s] = now;
        v.count = tcnt[s];
        v.allowed = tcnt[s] <= req_limit;
      end
    end
    v.used = USED_W'(live);
  endtask

  always @(posedge clk) begin
    verdict_t v, w;
    if (!rst_n) begin
      req_limit = '0;
      win_secs = '0;
      key_cap = TKL_RESET;
      wipe_table();
      verdict_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          report("unexpected out beat", 0, 0);
        end else begin
          w = verdict_q.pop_front();
          if (out_allowed !== w.allowed) report("allowed", out_allowed, w.allowed);
          if (out_window_count !== w.count)
            report("window_count", out_window_count, w.count);
          if (out_entries_used !== w.used)
            report("entries_used", out_entries_used, w.used);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_REQUEST_LIMIT) begin
          req_limit = cfg_data;
          wipe_table();
        end else if (cfg_index == REG_WINDOW_SECS) begin
          win_secs = cfg_data;
          wipe_table();
        end else if (cfg_index == REG_TRACKED_LIMIT) begin
          key_cap = cfg_data[TKL_W-1:0];
          wipe_table();
        end
      end
      if (in_valid && in_ready) begin
        rate_decision(in_command, in_key_id, in_key_present, in_time_ms, v);
        verdict_q.push_back(v);
      end
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// top of the rate limiter testbench: clock, reset, cfg writes, in and out beats
// with random idling; depends on pkwrl_pkg, per_key_window_rate_limiter, rate_limit_checker

module testbench;
  import pkwrl_pkg::*;

  localparam int SETTLE = 300;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic in_command = CMD_CHECK;
  logic [KEY_W-1:0] in_key_id = '0;
  logic in_key_present = 1'b0;
  logic [TIME_W-1:0] in_time_ms = '0;
  logic out_valid, out_ready = 1'b0, out_allowed;
  logic [CNT_W-1:0] out_window_count;
  logic [USED_W-1:0] out_entries_used;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RL_W-1:0] cfg_data = '0;
  int pending, failures;
  int cycles = 0;
  int tx_idle_pct = 28, rx_idle_pct = 45;
  int rx_hold = 0;
  logic [TIME_W-1:0] clock_ms;
  logic [KEY_W-1:0] key_pool[72];
  int pool_n;
  int win_s;

  always #4 clk = ~clk;

  per_key_window_rate_limiter i_dut (.*);

  rate_limit_checker i_checker (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready = 1'b0;
    end else begin
      out_ready = $urandom_range(99) >= rx_idle_pct;
    end
  end

  task automatic send_beat(logic cmd, logic [KEY_W-1:0] k, logic pres,
                           logic [TIME_W-1:0] t);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_command = cmd;
    in_key_id = k;
    in_key_present = pres;
    in_time_ms = t;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RL_W-1:0] d);
    wait (pending == 0);
    repeat (SETTLE) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_limits(int rl, int ws, int cap);
    write_reg(REG_REQUEST_LIMIT, RL_W'(rl));
    write_reg(REG_WINDOW_SECS, WS_W'(ws));
    write_reg(REG_TRACKED_LIMIT, {9'($urandom), TKL_W'(cap)});
    win_s = ws;
    pool_n = (cap == 0 ? 1 : cap > 64 ? 64 : cap) + 7;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 72; i++) key_pool[i] = {$urandom, $urandom};
  endtask

  task automatic random_beats(int n);
    int r;
    logic [KEY_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 55) clock_ms += $urandom_range(60);
      else if (r < 85) clock_ms += $urandom_range(1600);
      else if (r < 97) clock_ms += $urandom_range(win_s * 1000 + 2500);
      else clock_ms += $urandom;
      k = ($urandom_range(99) < 5) ? {$urandom, $urandom} : key_pool[$urandom_range(pool_n)];
      send_beat($urandom_range(99) < 12, k, $urandom_range(99) < 95, clock_ms);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed: count, saturation, eviction, removes, empty key, expiry
    clock_ms = 32'hFFFF_FC00;
    set_limits(2, 1, 2);
    write_reg(REG_SPARE, 16'hFFFF);
    send_beat(CMD_CHECK, 64'h0, 1'b1, clock_ms);
    send_beat(CMD_CHECK, 64'h0, 1'b1, clock_ms + 1);
    send_beat(CMD_CHECK, 64'h0, 1'b1, clock_ms + 2);
    send_beat(CMD_CHECK, 64'h0, 1'b1, clock_ms + 3);
    send_beat(CMD_CHECK, '1, 1'b1, clock_ms + 4);
    send_beat(CMD_CHECK, 64'h5555_AAAA_0F0F_F0F0, 1'b1, clock_ms + 5);
    send_beat(CMD_CHECK, '1, 1'b0, clock_ms + 6);
    send_beat(CMD_REMOVE, '1, 1'b1, clock_ms + 6);
    send_beat(CMD_REMOVE, 64'h1234, 1'b1, clock_ms + 6);
    send_beat(CMD_REMOVE, 64'h5555_AAAA_0F0F_F0F0, 1'b0, clock_ms + 7);
    send_beat(CMD_CHECK, 64'h5555_AAAA_0F0F_F0F0, 1'b1, clock_ms + 900);
    clock_ms += 32'd2000;
    send_beat(CMD_CHECK, 64'h5555_AAAA_0F0F_F0F0, 1'b1, clock_ms);
    send_beat(CMD_CHECK, 64'hAAAA_5555_F0F0_0F0F, 1'b1, clock_ms + 1000);
    send_beat(CMD_CHECK, 64'h5555_AAAA_0F0F_F0F0, 1'b1, clock_ms + 1001);
    send_beat(CMD_CHECK, 64'h0, 1'b1, clock_ms + 1002);

    set_limits(3, 1, 4);
    random_beats(110);
    set_limits(2, 1, 16);
    fork
      begin
        repeat (20) @(negedge clk);
        rx_hold = 600;
      end
      random_beats(110);
    join
    set_limits(65535, 65535, 127);
    random_beats(110);
    tx_idle_pct = 45;
    rx_idle_pct = 28;
    set_limits(2, 0, 0);
    random_beats(100);
    set_limits(0, 3, 64);
    random_beats(100);
    set_limits(1, 2, 1);
    random_beats(110);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_limits(5, 1, 64);
    random_beats(185);
    set_limits(4, 3, 8);
    random_beats(110);

    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
